### hw/rtl/sliding_window_maximum_macros.svh
// assertion macros for the port-level checker file
`ifndef SLIDING_WINDOW_MAXIMUM_MACROS_SVH
`define SLIDING_WINDOW_MAXIMUM_MACROS_SVH

// clocked assertion, switched off while reset is held
`define SWM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds across reset
`define SWM_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/swm_pkg.sv
// shared types and constants for the sliding window maximum block
`timescale 1ns / 1ps

package swm_pkg;

  localparam int DATA_W = 32;
  localparam int CFG_W  = 7;

  // per-cycle command broadcast along the cell row
  typedef struct packed {
    logic accept;  // a sample transaction is taken this cycle
    logic pop;     // the front candidate leaves, the row shifts by one
    logic clear;   // the accepted sample ends its sequence
  } swm_ctl_t;

endpackage

### hw/rtl/sliding_window_maximum.sv
// sliding window maximum: the result register loads from the sample transaction as it is taken
// throughput one sample per cycle while the output register is free or read; after a window shrink each
// expired front candidate beyond the first holds off the input during the one-step shift of the cell row
// sync active-low reset empties the row, zeroes position and fill counters,
// drops any pending result and sets window_size to 1
`timescale 1ns / 1ps

module sliding_window_maximum import swm_pkg::*; #(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // [31:0] sample_value
  input  logic              in_tlast,   // last_sample
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // [31:0] window_max
  output logic              out_tlast,  // last_result
  input  logic              cfg_wr_en,
  input  logic [CFG_W-1:0]  cfg_wr_data
);

  localparam int SW      = SAMPLE_WIDTH;
  localparam int POS_MOD = 2 * WINDOW_MAX;
  localparam int PW      = $clog2(POS_MOD);
  localparam logic [PW:0] POS_MOD_V = (PW + 1)'(POS_MOD);

  logic [PW-1:0] k_r, k_nxt;
  logic [PW-1:0] sp_r, sp_inc;
  logic [PW-1:0] seen_r, seen_inc;

  logic              out_tvalid_r;
  logic [DATA_W-1:0] out_data_r;
  logic              out_last_r;

  logic [WINDOW_MAX:0]         c_valid;
  logic [WINDOW_MAX:0][SW-1:0] c_value;
  logic [WINDOW_MAX:0][PW-1:0] c_pos;
  logic [WINDOW_MAX:0]         c_keep;
  logic [WINDOW_MAX-1:0]         c_skeep;
  logic [WINDOW_MAX-1:0][SW-1:0] c_head;

  logic [SW+DATA_W-1:0] key_ext;
  logic [SW-1:0]        key;
  logic [SW+DATA_W-1:0] res_ext;
  logic [PW:0]          age0, age1;
  logic                 exp0, exp1;
  logic                 accept;
  logic                 produced;
  swm_ctl_t             ctl;

  // effective window length
  always_comb begin
    if (cfg_wr_data == '0) begin
      k_nxt = PW'(1);
    end else if (int'(cfg_wr_data) > WINDOW_MAX) begin
      k_nxt = PW'(WINDOW_MAX);
    end else begin
      k_nxt = PW'(cfg_wr_data);
    end
  end

  assign key_ext = {{SW{1'b0}}, in_tdata};
  assign key     = key_ext[SW-1:0];

  // age of the two oldest candidates, modulo the position range
  assign age0 = (sp_r >= c_pos[0]) ? ({1'b0, sp_r} - {1'b0, c_pos[0]})
                                   : ({1'b0, sp_r} + POS_MOD_V - {1'b0, c_pos[0]});
  assign age1 = (sp_r >= c_pos[1]) ? ({1'b0, sp_r} - {1'b0, c_pos[1]})
                                   : ({1'b0, sp_r} + POS_MOD_V - {1'b0, c_pos[1]});
  assign exp0 = c_valid[0] && (age0 >= {1'b0, k_r});
  assign exp1 = c_valid[1] && (age1 >= {1'b0, k_r});

  // take a sample once at most one front candidate is left to expire and the output register is free or read
  assign in_tready = !(exp0 && exp1) && (!out_tvalid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  assign ctl.accept = accept;
  assign ctl.pop    = in_tvalid && exp0;
  assign ctl.clear  = accept && in_tlast;

  assign sp_inc   = (sp_r == PW'(POS_MOD - 1)) ? '0 : sp_r + 1'b1;
  assign seen_inc = (seen_r < k_r) ? seen_r + 1'b1 : k_r;
  assign produced = (seen_inc == k_r);

  // entry past the end of the row is always empty
  assign c_valid[WINDOW_MAX] = 1'b0;
  assign c_value[WINDOW_MAX] = '0;
  assign c_pos[WINDOW_MAX]   = '0;
  assign c_keep[WINDOW_MAX]  = 1'b0;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic prev_skeep;
    if (i == 0) begin : g_front
      assign prev_skeep = 1'b1;
    end else begin : g_rest
      assign prev_skeep = c_skeep[i-1];
    end

    swm_cell #(
      .SW (SW),
      .PW (PW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .key        (key),
      .key_pos    (sp_r),
      .nxt_valid  (c_valid[i+1]),
      .nxt_value  (c_value[i+1]),
      .nxt_pos    (c_pos[i+1]),
      .nxt_keep   (c_keep[i+1]),
      .prev_skeep (prev_skeep),
      .valid_o    (c_valid[i]),
      .value_o    (c_value[i]),
      .pos_o      (c_pos[i]),
      .keep_o     (c_keep[i]),
      .skeep_o    (c_skeep[i]),
      .head_o     (c_head[i])
    );
  end

  // front of the row after this sample is the window maximum
  assign res_ext = {{DATA_W{1'b0}}, c_head[0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r    <= PW'(1);
      sp_r   <= '0;
      seen_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        k_r <= k_nxt;
      end
      if (accept) begin
        sp_r   <= in_tlast ? '0 : sp_inc;
        seen_r <= in_tlast ? '0 : seen_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (accept) begin
      out_tvalid_r <= produced;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res_ext[DATA_W-1:0];
      out_last_r <= in_tlast;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

### hw/rtl/swm_cell.sv
// one cell of the candidate row: holds one deque entry and shifts toward the front
`timescale 1ns / 1ps

module swm_cell import swm_pkg::*; #(
  parameter int SW = 32,
  parameter int PW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  swm_ctl_t      ctl,
  input  logic [SW-1:0] key,
  input  logic [PW-1:0] key_pos,
  input  logic          nxt_valid,
  input  logic [SW-1:0] nxt_value,
  input  logic [PW-1:0] nxt_pos,
  input  logic          nxt_keep,
  input  logic          prev_skeep,
  output logic          valid_o,
  output logic [SW-1:0] value_o,
  output logic [PW-1:0] pos_o,
  output logic          keep_o,
  output logic          skeep_o,
  output logic [SW-1:0] head_o
);

  logic          valid_r, valid_nxt;
  logic [SW-1:0] value_r, value_nxt;
  logic [PW-1:0] pos_r, pos_nxt;

  logic          keep;
  logic          s_valid;
  logic [SW-1:0] s_value;
  logic [PW-1:0] s_pos;
  logic          s_keep;

  // candidate survives the new sample only if strictly greater
  assign keep = valid_r && ($signed(value_r) > $signed(key));

  // view of the row after the optional shift
  assign s_valid = ctl.pop ? nxt_valid : valid_r;
  assign s_value = ctl.pop ? nxt_value : value_r;
  assign s_pos   = ctl.pop ? nxt_pos   : pos_r;
  assign s_keep  = ctl.pop ? nxt_keep  : keep;

  assign valid_o = valid_r;
  assign value_o = value_r;
  assign pos_o   = pos_r;
  assign keep_o  = keep;
  assign skeep_o = s_keep;
  assign head_o  = s_keep ? s_value : key;

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    pos_nxt   = pos_r;
    if (ctl.accept) begin
      // first dropped slot after the kept prefix takes the new sample
      valid_nxt = s_keep || prev_skeep;
      value_nxt = s_keep ? s_value : key;
      pos_nxt   = s_keep ? s_pos   : key_pos;
      if (ctl.clear) begin
        valid_nxt = 1'b0;
      end
    end else if (ctl.pop) begin
      valid_nxt = s_valid;
      value_nxt = s_value;
      pos_nxt   = s_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    pos_r   <= pos_nxt;
  end

endmodule

### hw/rtl/swm_checker.sv
// port-level checker for the sliding window maximum, bound to the top level
`timescale 1ns / 1ps
`include "sliding_window_maximum_macros.svh"

module swm_checker import swm_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [DATA_W-1:0] out_tdata,
  input logic              out_tlast
);

  // a waiting result keeps its payload
  `SWM_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "result changed while stalled")

  // no sample taken while a result is stuck in the output register
  `SWM_ASSERT(a_stall_blocks_in, out_tvalid && !out_tready |-> !in_tready, "sample taken while output stalled")

  // every new result comes from a sample transaction in the cycle before
  `SWM_ASSERT(a_out_from_in, $rose(out_tvalid) |-> $past(in_tvalid && in_tready), "result without a sample")

  // reset drops any pending result
  `SWM_ASSERT_RST(a_rst_empty, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind sliding_window_maximum swm_checker u_swm_checker (.*);

### tb/sliding_window_maximum_tb.sv
// self-checking testbench for the sliding window maximum block
`timescale 1ns / 1ps

module sliding_window_maximum_tb;
  import swm_pkg::*;

  localparam int DEPTH       = 64;
  localparam int IDLE_LIMIT  = 2000;
  localparam int SETTLE      = 100;
  localparam int REPORT_MAX  = 10;
  localparam logic signed [DATA_W-1:0] MOST_NEG = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] MOST_POS = 32'sh7fff_ffff;

  typedef struct {
    logic signed [DATA_W-1:0] window_max;
    logic                     last_result;
  } max_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata = '0;    // [31:0] sample_value
  logic              in_tlast = 1'b0;  // last_sample
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;        // [31:0] window_max
  logic              out_tlast;        // last_result
  logic              cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]  cfg_wr_data = '0;

  // predictor state: deque of candidate maxima in a ring of DEPTH slots
  logic signed [DATA_W-1:0] cand_value [DEPTH];
  logic [6:0]               cand_pos [DEPTH];
  logic [5:0]               deque_front = '0;
  int                       deque_len = 0;
  logic [6:0]               next_pos = '0;
  int                       fill_count = 0;
  logic [CFG_W-1:0]         window_len = 7'd1;

  max_result_t              pending_maxima[$];
  int                       mismatches = 0;
  int                       idle_cycles = 0;
  logic signed [DATA_W-1:0] prev_sample = '0;
  int                       ready_left = 0;
  logic                     ready_phase = 1'b0;

  sliding_window_maximum dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // zero is taken as one, anything past the ring depth saturates
  function automatic int span_of(logic [CFG_W-1:0] w);
    if (w == 0) return 1;
    if (w > DEPTH) return DEPTH;
    return int'(w);
  endfunction

  task automatic track_window_max(input logic signed [DATA_W-1:0] s, input logic l);
    int          span;
    logic [6:0]  age;
    logic [5:0]  tail;
    max_result_t r;
    span = span_of(window_len);
    while (deque_len > 0) begin
      age = next_pos - cand_pos[deque_front];
      if (int'(age) < span) break;
      deque_front++;
      deque_len--;
    end
    // equal or smaller candidates lose to the newer sample
    while (deque_len > 0) begin
      tail = deque_front + 6'(deque_len - 1);
      if (cand_value[tail] > s) break;
      deque_len--;
    end
    if (deque_len >= DEPTH) begin
      deque_front++;
      deque_len--;
    end
    tail = deque_front + 6'(deque_len);
    cand_value[tail] = s;
    cand_pos[tail] = next_pos;
    deque_len++;
    next_pos++;
    if (fill_count < span) fill_count++;
    if (fill_count > span) fill_count = span;
    if (fill_count >= span) begin
      r.window_max = cand_value[deque_front];
      r.last_result = l;
      pending_maxima = {pending_maxima, r};
    end
    if (l) begin
      deque_front = '0;
      deque_len = 0;
      next_pos = '0;
      fill_count = 0;
    end
  endtask

  // valid stays high on return so back-to-back samples need no gap
  task automatic push_sample(input logic signed [DATA_W-1:0] s, input logic l);
    in_tvalid <= 1'b1;
    in_tdata <= s;
    in_tlast <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_window_max(s, l);
  endtask

  // drain every result and let the row settle before touching the register
  task automatic write_window(input logic [CFG_W-1:0] w);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_maxima.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    window_len = w;
  endtask

  function automatic logic signed [DATA_W-1:0] next_sample(input int trend);
    logic signed [DATA_W-1:0] s;
    if ($urandom_range(0, 15) == 0) begin
      case ($urandom_range(0, 3))
        0: s = MOST_NEG;
        1: s = MOST_POS;
        2: s = '0;
        default: s = -1;
      endcase
    end else begin
      case (trend)
        0: s = $urandom;
        1: s = $signed(DATA_W'($urandom_range(0, 8))) - 4;
        2: s = prev_sample - $signed(DATA_W'($urandom_range(0, 3)));
        default: s = prev_sample + $signed(DATA_W'($urandom_range(0, 3)));
      endcase
    end
    prev_sample = s;
    return s;
  endfunction

  task automatic test_reset_window;
    push_sample(MOST_POS, 1'b0);
    push_sample(MOST_NEG, 1'b0);
    push_sample('0, 1'b0);
    push_sample(-1, 1'b1);
  endtask

  task automatic test_zero_window;
    write_window(7'd0);
    push_sample(32'sh5555_5555, 1'b0);
    push_sample(32'shaaaa_aaaa, 1'b1);
  endtask

  task automatic test_small_window;
    write_window(7'd3);
    // ties, then a rise whose peak stays the maximum to the end
    push_sample(5, 1'b0);
    push_sample(5, 1'b0);
    push_sample(7, 1'b0);
    push_sample(1, 1'b0);
    push_sample(0, 1'b1);
    // sequence shorter than the window gives nothing
    push_sample(9, 1'b0);
    push_sample(1, 1'b1);
  endtask

  task automatic test_window_change;
    push_sample(3, 1'b0);
    push_sample(2, 1'b0);
    push_sample(1, 1'b0);
    write_window(7'd5);
    push_sample(0, 1'b0);
    push_sample(-1, 1'b0);
    push_sample(-2, 1'b1);
    push_sample(10, 1'b0);
    push_sample(9, 1'b0);
    push_sample(8, 1'b0);
    push_sample(7, 1'b0);
    // shrink leaves several front candidates expired for the next sample
    write_window(7'd2);
    push_sample(6, 1'b1);
  endtask

  task automatic test_oversize_window;
    write_window(7'd127);
    push_sample(-5, 1'b0);
    push_sample(4, 1'b1);
  endtask

  task automatic test_random_sequences(input int items);
    int sent;
    int seq_len;
    int span;
    int trend;
    int burst_left;
    int k;
    logic l;
    sent = 0;
    burst_left = $urandom_range(1, 40);
    write_window(7'd64);
    while (sent < items) begin
      if (sent > 0 && $urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 5))
          0: write_window(7'd0);
          1: write_window(7'd1);
          2: write_window(7'd64);
          3: write_window(7'd127);
          4: write_window(7'($urandom_range(2, 8)));
          default: write_window(7'($urandom));
        endcase
      end else if (sent > 0 && $urandom_range(0, 9) == 0) begin
        // sender holds off until the receiver has caught up
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_maxima.size() != 0) @(posedge clk);
      end
      span = span_of(window_len);
      case ($urandom_range(0, 9))
        0, 1, 2: seq_len = (span > 1) ? $urandom_range(1, span - 1) : 1;
        8, 9:    seq_len = $urandom_range(100, 200);
        default: seq_len = span + $urandom_range(0, 24);
      endcase
      if (seq_len > items - sent) seq_len = items - sent;
      trend = $urandom_range(0, 3);
      for (k = 0; k < seq_len; k++) begin
        l = (k == seq_len - 1) && ($urandom_range(0, 9) != 0);
        push_sample(next_sample(trend), l);
        sent++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          if ($urandom_range(0, 3) != 0) begin
            in_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
          end
        end
      end
    end
  endtask

  // receiver alternates ready runs and stalls, sometimes a long clean stretch
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_phase = !ready_phase;
      if (ready_phase)
        ready_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 40);
      else
        ready_left = $urandom_range(1, 10);
    end
    ready_left--;
    out_tready <= ready_phase;
  end

  task automatic note_mismatch(input string what, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("%0t: %s mismatch, expected %0d (0x%08h), got %0d (0x%08h)", $realtime, what,
               $signed(want), want, $signed(got), got);
  endtask

  always @(posedge clk) begin : check_results
    max_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_maxima.size() == 0) begin
        note_mismatch("unexpected transaction", '0, out_tdata);
      end else begin
        want = pending_maxima[0];
        pending_maxima.delete(0);
        if (out_tdata !== want.window_max)
          note_mismatch("window_max", want.window_max, out_tdata);
        if (out_tlast !== want.last_result)
          note_mismatch("last_result", DATA_W'(want.last_result), DATA_W'(out_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("sliding_window_maximum verification failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_window();
    test_zero_window();
    test_small_window();
    test_window_change();
    test_oversize_window();
    test_random_sequences(625);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_maxima.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && pending_maxima.size() == 0) begin
      $display("sliding_window_maximum verification clean");
    end else begin
      $display("sliding_window_maximum verification failed");
    end
    $finish;
  end

endmodule
